// ===== design/irc_fcd_pkg.sv =====
package irc_fcd_pkg;

	// One received text byte
	typedef struct packed {
		logic [7:0] text_byte;
		logic       block_start;
	} in_item_t;

	// One displayed byte with its style
	typedef struct packed {
		logic [7:0] shown_byte;
		logic       is_bold;
		logic       is_italic;
		logic       is_underlined;
		logic [3:0] fore_colour;
		logic [4:0] back_colour;
		logic       last_of_run;
	} out_item_t;

	// Control codes and special characters
	localparam logic [7:0] CODE_NUL       = 8'h00;
	localparam logic [7:0] CODE_BOLD      = 8'h02;
	localparam logic [7:0] CODE_COLOUR    = 8'h03;
	localparam logic [7:0] CODE_PLAIN     = 8'h0F;
	localparam logic [7:0] CODE_ITALIC    = 8'h1D;
	localparam logic [7:0] CODE_UNDERLINE = 8'h1F;
	localparam logic [7:0] CH_NEWLINE     = 8'h0A;
	localparam logic [7:0] CH_SPACE       = 8'h20;
	localparam logic [7:0] CH_COMMA       = 8'h2C;
	localparam logic [7:0] CH_ZERO        = 8'h30;
	localparam logic [7:0] CH_NINE        = 8'h39;
	localparam logic [7:0] CH_LT          = 8'h3C;
	localparam logic [7:0] CH_GT          = 8'h3E;

	// Palette
	localparam logic [3:0] FORE_WHITE       = 4'd0;
	localparam logic [3:0] FORE_BLACK       = 4'd1;
	localparam logic [3:0] FORE_GREEN       = 4'd3;
	localparam logic [3:0] FORE_CYAN        = 4'd10;
	localparam logic [4:0] BACK_WHITE       = 5'd0;
	localparam logic [4:0] BACK_TRANSPARENT = 5'd16;
	localparam logic [6:0] PALETTE_MAX      = 7'd15;

	// Colour code parse phases
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_OPEN  = 3'd1;
	localparam logic [2:0] PH_FORE1 = 3'd2;
	localparam logic [2:0] PH_FORE2 = 3'd3;
	localparam logic [2:0] PH_COMMA = 3'd4;
	localparam logic [2:0] PH_BACK1 = 3'd5;

	// Header rule phases
	localparam logic [1:0] HDR_NONE = 2'd0;
	localparam logic [1:0] HDR_NICK = 2'd1;
	localparam logic [1:0] HDR_DONE = 2'd2;

	// Result queue
	localparam int unsigned RES_DEPTH = 4;
	localparam int unsigned RES_AW    = $clog2(RES_DEPTH);

endpackage

// ===== design/irc_fcd_stream_if.sv =====
interface irc_fcd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/irc_format_code_decoder_core.sv =====
// Chat text formatting decoder. Takes one text byte per beat on text_in and
// gives printable bytes on text_out, each tagged with bold, italic, underline
// and foreground/background palette indices. Control bytes (bold, italic,
// underline toggles, plain reset, colour codes) update the style and give no
// beat of their own; a byte gives zero, one or two result beats, the second
// only when a bare comma ending a colour code is echoed ahead of it, and
// last_of_run marks the final beat of each byte. A byte is decoded in the
// cycle it is accepted and its results land in a four-entry result queue, so
// one byte is taken every cycle while the sink keeps up; text_in.ready drops
// only when fewer than two queue entries are free. Results of an accepted byte
// are registered in the queue before they reach text_out.
module irc_format_code_decoder_core (
	input  logic              clk,
	input  logic              arst_n,
	irc_fcd_stream_if.sink    text_in,
	irc_fcd_stream_if.source  text_out
);

	// Style and parser state
	logic       bold_q, ital_q, und_q;
	logic [3:0] fore_q;
	logic [4:0] back_q;
	logic [1:0] space_q, hdr_q;
	logic [2:0] phase_q;
	logic [6:0] fdig_q, bdig_q;
	logic       fseen_q;

	// Next state from the decoder
	logic       bold_c, ital_c, und_c;
	logic [3:0] fore_c;
	logic [4:0] back_c;
	logic [1:0] space_c, hdr_c;
	logic [2:0] phase_c, ph;
	logic [6:0] fdig_c, bdig_c;
	logic       fseen_c;

	// Decode control
	logic [7:0] b;
	logic       bs, dig, rs, bv, plain, comma;
	logic [3:0] dv;
	logic [1:0] n_c;
	irc_fcd_pkg::out_item_t res_c [2];

	// Result queue
	irc_fcd_pkg::out_item_t res_q [irc_fcd_pkg::RES_DEPTH];
	logic [irc_fcd_pkg::RES_AW-1:0] wr_q, rd_q;
	logic [irc_fcd_pkg::RES_AW:0]   cnt_q;
	logic in_fire, out_fire;
	logic [1:0] push;

	function automatic irc_fcd_pkg::out_item_t make_res(
		input logic [7:0] ch, input logic bo, input logic it, input logic un,
		input logic [3:0] fo, input logic [4:0] ba);
		irc_fcd_pkg::out_item_t r;
		r.shown_byte    = ch;
		r.is_bold       = bo;
		r.is_italic     = it;
		r.is_underlined = un;
		r.fore_colour   = fo;
		r.back_colour   = ba;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	always_comb begin
		b   = text_in.payload.text_byte;
		bs  = text_in.payload.block_start;
		dig = b inside {[irc_fcd_pkg::CH_ZERO:irc_fcd_pkg::CH_NINE]};
		dv  = b[3:0];
		// treat unused phase codes as idle
		ph  = (phase_q > irc_fcd_pkg::PH_BACK1) ? irc_fcd_pkg::PH_IDLE : phase_q;

		bold_c  = bold_q;
		ital_c  = ital_q;
		und_c   = und_q;
		fore_c  = fore_q;
		back_c  = back_q;
		space_c = space_q;
		hdr_c   = hdr_q;
		phase_c = ph;
		fdig_c  = fdig_q;
		bdig_c  = bdig_q;
		fseen_c = fseen_q;
		n_c     = 2'd0;
		res_c[0] = '0;
		res_c[1] = '0;
		rs    = 1'b0;
		bv    = 1'b0;
		plain = 1'b0;
		comma = 1'b0;

		// Step 1: advance the colour code parser, or decide to end it
		if (bs) begin
			rs    = (ph != irc_fcd_pkg::PH_IDLE);
			bv    = (ph == irc_fcd_pkg::PH_BACK1);
			plain = 1'b1;
		end else begin
			case (ph)
				irc_fcd_pkg::PH_OPEN: begin
					if (dig) begin
						fdig_c  = {3'd0, dv};
						fseen_c = 1'b1;
						phase_c = irc_fcd_pkg::PH_FORE1;
					end else if (b == irc_fcd_pkg::CH_COMMA) begin
						phase_c = irc_fcd_pkg::PH_COMMA;
					end else begin
						rs    = 1'b1;
						plain = 1'b1;
					end
				end
				irc_fcd_pkg::PH_FORE1: begin
					if (dig) begin
						fdig_c  = 7'(fdig_q * 7'd10 + {3'd0, dv});
						phase_c = irc_fcd_pkg::PH_FORE2;
					end else if (b == irc_fcd_pkg::CH_COMMA) begin
						phase_c = irc_fcd_pkg::PH_COMMA;
					end else begin
						rs    = 1'b1;
						plain = 1'b1;
					end
				end
				irc_fcd_pkg::PH_FORE2: begin
					if (b == irc_fcd_pkg::CH_COMMA) begin
						phase_c = irc_fcd_pkg::PH_COMMA;
					end else begin
						rs    = 1'b1;
						plain = 1'b1;
					end
				end
				irc_fcd_pkg::PH_COMMA: begin
					if (dig) begin
						bdig_c  = {3'd0, dv};
						phase_c = irc_fcd_pkg::PH_BACK1;
					end else begin
						rs    = 1'b1;
						plain = 1'b1;
					end
				end
				irc_fcd_pkg::PH_BACK1: begin
					rs = 1'b1;
					bv = 1'b1;
					if (dig) begin
						// second background digit closes the code and is consumed
						bdig_c = 7'(bdig_q * 7'd10 + {3'd0, dv});
					end else begin
						plain = 1'b1;
					end
				end
				default: plain = 1'b1;
			endcase
		end

		// Step 2: resolve a finished colour code, echoing a bare comma
		if (rs) begin
			comma = (ph == irc_fcd_pkg::PH_COMMA);
			if (fseen_c && fdig_c <= irc_fcd_pkg::PALETTE_MAX)
				fore_c = fdig_c[3:0];
			else
				fore_c = irc_fcd_pkg::FORE_WHITE;
			if (bv && bdig_c <= irc_fcd_pkg::PALETTE_MAX)
				back_c = bdig_c[4:0];
			else if (fseen_c && fdig_c == {3'd0, irc_fcd_pkg::FORE_BLACK})
				back_c = irc_fcd_pkg::BACK_WHITE;
			else
				back_c = irc_fcd_pkg::BACK_TRANSPARENT;
			phase_c = irc_fcd_pkg::PH_IDLE;
			if (comma) begin
				res_c[0] = make_res(irc_fcd_pkg::CH_COMMA, bold_c, ital_c, und_c,
					fore_c, back_c);
				n_c = 2'd1;
			end
		end

		// Step 3: block start restores the start style
		if (bs) begin
			bold_c  = 1'b0;
			ital_c  = 1'b0;
			und_c   = 1'b0;
			fore_c  = irc_fcd_pkg::FORE_GREEN;
			back_c  = irc_fcd_pkg::BACK_TRANSPARENT;
			hdr_c   = irc_fcd_pkg::HDR_NONE;
			space_c = 2'd0;
			phase_c = irc_fcd_pkg::PH_IDLE;
		end

		// Step 4: decode the byte itself
		if (plain) begin
			case (b)
				irc_fcd_pkg::CODE_NUL: ;
				irc_fcd_pkg::CODE_PLAIN: begin
					bold_c = 1'b0;
					ital_c = 1'b0;
					und_c  = 1'b0;
					fore_c = irc_fcd_pkg::FORE_WHITE;
					back_c = irc_fcd_pkg::BACK_TRANSPARENT;
				end
				irc_fcd_pkg::CODE_COLOUR: begin
					phase_c = irc_fcd_pkg::PH_OPEN;
					fseen_c = 1'b0;
					fdig_c  = 7'd0;
					bdig_c  = 7'd0;
				end
				irc_fcd_pkg::CODE_BOLD:      bold_c = ~bold_c;
				irc_fcd_pkg::CODE_ITALIC:    ital_c = ~ital_c;
				irc_fcd_pkg::CODE_UNDERLINE: und_c  = ~und_c;
				irc_fcd_pkg::CH_LT: begin
					// after two leading spaces the bracket shows white, the nick cyan
					if (space_c == 2'd2)
						fore_c = irc_fcd_pkg::FORE_WHITE;
					res_c[n_c[0]] = make_res(b, bold_c, ital_c, und_c, fore_c, back_c);
					n_c = n_c + 2'd1;
					if (space_c == 2'd2 && hdr_c == irc_fcd_pkg::HDR_NONE) begin
						fore_c = irc_fcd_pkg::FORE_CYAN;
						hdr_c  = irc_fcd_pkg::HDR_NICK;
					end
				end
				irc_fcd_pkg::CH_GT: begin
					if (hdr_c == irc_fcd_pkg::HDR_NICK) begin
						fore_c = irc_fcd_pkg::FORE_WHITE;
						hdr_c  = irc_fcd_pkg::HDR_DONE;
					end
					res_c[n_c[0]] = make_res(b, bold_c, ital_c, und_c, fore_c, back_c);
					n_c = n_c + 2'd1;
				end
				irc_fcd_pkg::CH_NEWLINE: begin
					space_c = 2'd0;
					bold_c  = 1'b0;
					ital_c  = 1'b0;
					und_c   = 1'b0;
					fore_c  = irc_fcd_pkg::FORE_GREEN;
					back_c  = irc_fcd_pkg::BACK_TRANSPARENT;
					hdr_c   = irc_fcd_pkg::HDR_NONE;
					res_c[n_c[0]] = make_res(b, bold_c, ital_c, und_c, fore_c, back_c);
					n_c = n_c + 2'd1;
				end
				irc_fcd_pkg::CH_SPACE: begin
					if (space_c != 2'd3)
						space_c = space_c + 2'd1;
					res_c[n_c[0]] = make_res(b, bold_c, ital_c, und_c, fore_c, back_c);
					n_c = n_c + 2'd1;
				end
				default: begin
					res_c[n_c[0]] = make_res(b, bold_c, ital_c, und_c, fore_c, back_c);
					n_c = n_c + 2'd1;
				end
			endcase
		end

		// Mark the final beat of this byte
		if (n_c == 2'd2)
			res_c[1].last_of_run = 1'b1;
		else if (n_c == 2'd1)
			res_c[0].last_of_run = 1'b1;
	end

	// Take a byte only when two queue entries are free
	assign text_in.ready  = (cnt_q <= (irc_fcd_pkg::RES_AW+1)'(irc_fcd_pkg::RES_DEPTH - 2));
	assign in_fire        = text_in.valid && text_in.ready;
	assign text_out.valid = (cnt_q != '0);
	assign text_out.payload = res_q[rd_q];
	assign out_fire       = text_out.valid && text_out.ready;
	assign push           = in_fire ? n_c : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bold_q  <= 1'b0;
			ital_q  <= 1'b0;
			und_q   <= 1'b0;
			fore_q  <= irc_fcd_pkg::FORE_GREEN;
			back_q  <= irc_fcd_pkg::BACK_TRANSPARENT;
			space_q <= 2'd0;
			hdr_q   <= irc_fcd_pkg::HDR_NONE;
			phase_q <= irc_fcd_pkg::PH_IDLE;
			fdig_q  <= 7'd0;
			bdig_q  <= 7'd0;
			fseen_q <= 1'b0;
			wr_q    <= '0;
			rd_q    <= '0;
			cnt_q   <= '0;
		end else begin
			if (in_fire) begin
				bold_q  <= bold_c;
				ital_q  <= ital_c;
				und_q   <= und_c;
				fore_q  <= fore_c;
				back_q  <= back_c;
				space_q <= space_c;
				hdr_q   <= hdr_c;
				phase_q <= phase_c;
				fdig_q  <= fdig_c;
				bdig_q  <= bdig_c;
				fseen_q <= fseen_c;
			end
			wr_q  <= wr_q + irc_fcd_pkg::RES_AW'(push);
			if (out_fire)
				rd_q <= rd_q + irc_fcd_pkg::RES_AW'(1);
			cnt_q <= cnt_q + (irc_fcd_pkg::RES_AW+1)'(push)
				- (irc_fcd_pkg::RES_AW+1)'(out_fire);
		end
	end

	// Queue storage: payload only, no reset
	always_ff @(posedge clk) begin
		if (push != 2'd0)
			res_q[wr_q] <= res_c[0];
		if (push == 2'd2)
			res_q[wr_q + irc_fcd_pkg::RES_AW'(1)] <= res_c[1];
	end

endmodule
